// File: rtl/i2crm_pkg.sv
// Shared types and constants for the I2C register master.
package i2crm_pkg;

   // Command codes carried in the func field
   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_PUSH  = 2'd1;
   localparam logic [1:0] FUNC_WRITE = 2'd2;
   localparam logic [1:0] FUNC_READ  = 2'd3;

   // Completion status codes
   localparam logic [2:0] STAT_OK         = 3'd0;
   localparam logic [2:0] STAT_ADDR_NACK  = 3'd1;
   localparam logic [2:0] STAT_REG_NACK   = 3'd2;
   localparam logic [2:0] STAT_RADDR_NACK = 3'd3;
   localparam logic [2:0] STAT_DATA_NACK  = 3'd4;

   // Configuration register indexes
   localparam logic [1:0] CSR_DEV_ADDR  = 2'd0;
   localparam logic [1:0] CSR_ACK_TMO   = 2'd1;
   localparam logic [1:0] CSR_STOP_HOLD = 2'd2;

   // Configuration reset values
   localparam logic [6:0]  DEV_ADDR_RST  = 7'd104;
   localparam logic [7:0]  ACK_TMO_RST   = 8'd250;
   localparam logic [15:0] STOP_HOLD_RST = 16'd0;

   // ACK wait counter saturation value
   localparam logic [7:0] ACK_WAIT_MAX = 8'hFF;

   // Bus sequencer phases, one-hot
   typedef enum logic [13:0] {
      PH_IDLE       = 14'b00000000000001,
      PH_START1     = 14'b00000000000010,
      PH_TX_ADDR_W  = 14'b00000000000100,
      PH_ACK_ADDR_W = 14'b00000000001000,
      PH_TX_REG     = 14'b00000000010000,
      PH_ACK_REG    = 14'b00000000100000,
      PH_TX_DATA    = 14'b00000001000000,
      PH_ACK_DATA   = 14'b00000010000000,
      PH_START2     = 14'b00000100000000,
      PH_TX_ADDR_R  = 14'b00001000000000,
      PH_ACK_ADDR_R = 14'b00010000000000,
      PH_RX         = 14'b00100000000000,
      PH_MACK       = 14'b01000000000000,
      PH_STOP       = 14'b10000000000000
   } phase_type;

   // Configuration register set
   typedef struct packed {
      logic [6:0]  device_address;
      logic [7:0]  ack_timeout;
      logic [15:0] stop_hold_ticks;
   } cfg_type;

   // Input beat payload
   typedef struct packed {
      logic [1:0] func;
      logic       sda_sample;
      logic [7:0] register_address;
      logic [7:0] write_byte;
      logic [7:0] read_count;
   } req_type;

   // Result beat payload
   typedef struct packed {
      logic       scl_level;
      logic       sda_pull_low;
      logic       busy_res;
      logic [7:0] read_data;
      logic       read_valid;
      logic       read_last;
      logic       done_res;
      logic [2:0] status;
      logic [3:0] failed_byte;
   } rsp_type;

endpackage

// File: rtl/i2c_register_master.sv
// Top level of the I2C register master: handshake, config registers, result register.
// A result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle; an input beat is taken whenever the result register
// is empty or drains in the same cycle, so a held-off result stalls the input.
// Reset (synchronous): sequencer idle, write buffer empty, no result pending,
// config registers back to address 104, ACK timeout 250, stop hold 0.
module i2c_register_master #(
   parameter int WRITE_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  i2crm_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output i2crm_pkg::rsp_type rsp_data,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_write_data
);

   i2crm_pkg::cfg_type cfg_ff;
   i2crm_pkg::rsp_type rsp_ff;
   i2crm_pkg::rsp_type rsp_in;
   logic               rsp_valid_ff;
   logic               step;

   // Input beat taken whenever the result register is free or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address  <= i2crm_pkg::DEV_ADDR_RST;
         cfg_ff.ack_timeout     <= i2crm_pkg::ACK_TMO_RST;
         cfg_ff.stop_hold_ticks <= i2crm_pkg::STOP_HOLD_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            i2crm_pkg::CSR_DEV_ADDR:  cfg_ff.device_address  <= csr_write_data[6:0];
            i2crm_pkg::CSR_ACK_TMO:   cfg_ff.ack_timeout     <= csr_write_data[7:0];
            i2crm_pkg::CSR_STOP_HOLD: cfg_ff.stop_hold_ticks <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   i2crm_engine #(
      .WRITE_DEPTH(WRITE_DEPTH)
   ) u_engine (
      .clock(clock),
      .reset(reset),
      .step (step),
      .req  (req_data),
      .cfg  (cfg_ff),
      .rsp  (rsp_in)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: rtl/i2crm_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
module i2crm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/i2crm_engine.sv
// I2C bus sequencer: one quarter-bit tick per accepted beat.
module i2crm_engine #(
   parameter int WRITE_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  i2crm_pkg::req_type req,
   input  i2crm_pkg::cfg_type cfg,
   output i2crm_pkg::rsp_type rsp
);

   localparam int ADDR_W = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;
   localparam int IDX_W  = $clog2(WRITE_DEPTH + 1);

   i2crm_pkg::phase_type phase_ff, phase_in;
   logic [1:0]       qtr_ff, qtr_in;
   logic [3:0]       bit_ff, bit_in;
   logic [7:0]       shift_ff, shift_in;
   logic [7:0]       left_ff, left_in;
   logic [7:0]       wait_ff, wait_in;
   logic [IDX_W-1:0] fill_ff, fill_in;
   logic [15:0]      hold_ff, hold_in;
   logic [7:0]       treg_ff, treg_in;
   logic             is_read_ff, is_read_in;
   logic [2:0]       end_st_ff, end_st_in;
   logic [IDX_W-1:0] didx_ff, didx_in;

   logic             buf_we;
   logic [ADDR_W-1:0] buf_rd_addr;
   logic [7:0]       buf_rd_data;
   logic [IDX_W:0]   didx_plus;
   logic [IDX_W+3:0] didx_wide;

   // Write buffer; read side prefetches the next byte to send
   assign didx_plus   = {1'b0, didx_ff} + 1'b1;
   assign buf_rd_addr = (phase_ff == i2crm_pkg::PH_ACK_DATA) ? didx_plus[ADDR_W-1:0]
                                                           : didx_ff[ADDR_W-1:0];
   assign didx_wide   = (IDX_W+4)'(didx_ff);

   i2crm_ram #(
      .WIDTH (8),
      .DEPTH (WRITE_DEPTH),
      .ADDR_W(ADDR_W)
   ) u_wbuf (
      .clock  (clock),
      .wr_en  (step && buf_we),
      .wr_addr(fill_ff[ADDR_W-1:0]),
      .wr_data(req.write_byte),
      .rd_addr(buf_rd_addr),
      .rd_data(buf_rd_data)
   );

   // Next state and tick outputs
   always_comb begin
      i2crm_pkg::phase_type ph;
      logic [1:0]       q;
      logic             high;
      logic [7:0]       w;
      logic [7:0]       left_dec;
      logic [IDX_W-1:0] didx_nxt;

      phase_in   = phase_ff;
      qtr_in     = qtr_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      left_in    = left_ff;
      wait_in    = wait_ff;
      fill_in    = fill_ff;
      hold_in    = hold_ff;
      treg_in    = treg_ff;
      is_read_in = is_read_ff;
      end_st_in  = end_st_ff;
      didx_in    = didx_ff;
      buf_we     = 1'b0;
      rsp        = '0;
      rsp.scl_level = 1'b1;

      ph       = phase_ff;
      q        = qtr_ff;
      high     = (qtr_ff == 2'd1) || (qtr_ff == 2'd2);
      w        = 8'd0;
      left_dec = 8'd0;
      didx_nxt = '0;

      // Idle: stop hold countdown, buffer pushes and transaction start
      if (phase_ff == i2crm_pkg::PH_IDLE) begin
         if (hold_ff != 16'd0) begin
            hold_in = hold_ff - 16'd1;
         end else if (req.func == i2crm_pkg::FUNC_PUSH) begin
            if (fill_ff < IDX_W'(WRITE_DEPTH)) begin
               buf_we  = 1'b1;
               fill_in = fill_ff + 1'b1;
            end
         end else if (req.func == i2crm_pkg::FUNC_WRITE ||
                      req.func == i2crm_pkg::FUNC_READ) begin
            treg_in    = req.register_address;
            is_read_in = (req.func == i2crm_pkg::FUNC_READ);
            left_in    = (req.func == i2crm_pkg::FUNC_READ) ? req.read_count : 8'd0;
            didx_in    = '0;
            end_st_in  = i2crm_pkg::STAT_OK;
            phase_in   = i2crm_pkg::PH_START1;
            qtr_in     = 2'd0;
            ph         = i2crm_pkg::PH_START1;
            q          = 2'd0;
            high       = 1'b0;
         end
      end

      unique case (ph)
         i2crm_pkg::PH_IDLE: begin
         end

         // START and repeated START
         i2crm_pkg::PH_START1, i2crm_pkg::PH_START2: begin
            rsp.scl_level    = high;
            rsp.sda_pull_low = q[1];
            if (q == 2'd3) begin
               phase_in = (ph == i2crm_pkg::PH_START1) ? i2crm_pkg::PH_TX_ADDR_W
                                                      : i2crm_pkg::PH_TX_ADDR_R;
               shift_in = {cfg.device_address, (ph == i2crm_pkg::PH_START2)};
               bit_in   = 4'd0;
               qtr_in   = 2'd0;
            end else begin
               qtr_in = q + 2'd1;
            end
         end

         // Byte transmit, MSB first
         i2crm_pkg::PH_TX_ADDR_W, i2crm_pkg::PH_TX_REG,
         i2crm_pkg::PH_TX_DATA, i2crm_pkg::PH_TX_ADDR_R: begin
            rsp.scl_level    = high;
            rsp.sda_pull_low = ~shift_ff[7];
            if (q == 2'd3) begin
               shift_in = {shift_ff[6:0], 1'b0};
               bit_in   = bit_ff + 4'd1;
               if (bit_ff >= 4'd7) begin
                  unique case (ph)
                     i2crm_pkg::PH_TX_ADDR_W: phase_in = i2crm_pkg::PH_ACK_ADDR_W;
                     i2crm_pkg::PH_TX_REG:    phase_in = i2crm_pkg::PH_ACK_REG;
                     i2crm_pkg::PH_TX_DATA:   phase_in = i2crm_pkg::PH_ACK_DATA;
                     default:                 phase_in = i2crm_pkg::PH_ACK_ADDR_R;
                  endcase
                  bit_in  = 4'd0;
                  wait_in = 8'd0;
               end
               qtr_in = 2'd0;
            end else begin
               qtr_in = q + 2'd1;
            end
         end

         // Slave ACK slot; SCL held high at q2 until SDA goes low
         i2crm_pkg::PH_ACK_ADDR_W, i2crm_pkg::PH_ACK_REG,
         i2crm_pkg::PH_ACK_DATA, i2crm_pkg::PH_ACK_ADDR_R: begin
            rsp.scl_level = high;
            if (q == 2'd2) begin
               if (!req.sda_sample) begin
                  qtr_in = 2'd3;
               end else begin
                  w       = (wait_ff < i2crm_pkg::ACK_WAIT_MAX) ? wait_ff + 8'd1 : wait_ff;
                  wait_in = w;
                  if (w >= cfg.ack_timeout) begin
                     phase_in = i2crm_pkg::PH_STOP;
                     qtr_in   = 2'd0;
                     unique case (ph)
                        i2crm_pkg::PH_ACK_ADDR_W: end_st_in = i2crm_pkg::STAT_ADDR_NACK;
                        i2crm_pkg::PH_ACK_REG:    end_st_in = i2crm_pkg::STAT_REG_NACK;
                        i2crm_pkg::PH_ACK_ADDR_R: end_st_in = i2crm_pkg::STAT_RADDR_NACK;
                        default:                  end_st_in = i2crm_pkg::STAT_DATA_NACK;
                     endcase
                  end
               end
            end else if (q == 2'd3) begin
               qtr_in = 2'd0;
               bit_in = 4'd0;
               if (ph == i2crm_pkg::PH_ACK_ADDR_W) begin
                  phase_in = i2crm_pkg::PH_TX_REG;
                  shift_in = treg_ff;
               end else if (ph == i2crm_pkg::PH_ACK_REG && is_read_ff) begin
                  phase_in = i2crm_pkg::PH_START2;
               end else if (ph == i2crm_pkg::PH_ACK_REG || ph == i2crm_pkg::PH_ACK_DATA) begin
                  didx_nxt = (ph == i2crm_pkg::PH_ACK_DATA) ? didx_plus[IDX_W-1:0] : didx_ff;
                  didx_in  = didx_nxt;
                  if (didx_nxt < fill_ff && didx_nxt < IDX_W'(WRITE_DEPTH)) begin
                     phase_in = i2crm_pkg::PH_TX_DATA;
                     shift_in = buf_rd_data;
                  end else begin
                     phase_in  = i2crm_pkg::PH_STOP;
                     end_st_in = i2crm_pkg::STAT_OK;
                  end
               end else begin
                  if (left_ff != 8'd0) begin
                     phase_in = i2crm_pkg::PH_RX;
                     shift_in = 8'd0;
                  end else begin
                     phase_in  = i2crm_pkg::PH_STOP;
                     end_st_in = i2crm_pkg::STAT_OK;
                  end
               end
            end else begin
               qtr_in = q + 2'd1;
            end
         end

         // Byte receive; a byte completes at q2 of its last bit
         i2crm_pkg::PH_RX: begin
            rsp.scl_level = high;
            if (q == 2'd2) begin
               shift_in = {shift_ff[6:0], req.sda_sample};
               if (bit_ff == 4'd7) begin
                  rsp.read_valid = 1'b1;
                  rsp.read_data  = {shift_ff[6:0], req.sda_sample};
                  rsp.read_last  = (left_ff == 8'd1);
               end
               qtr_in = 2'd3;
            end else if (q == 2'd3) begin
               bit_in = bit_ff + 4'd1;
               if (bit_ff >= 4'd7) begin
                  bit_in   = 4'd0;
                  phase_in = i2crm_pkg::PH_MACK;
               end
               qtr_in = 2'd0;
            end else begin
               qtr_in = q + 2'd1;
            end
         end

         // Master ACK, NACK on the last byte
         i2crm_pkg::PH_MACK: begin
            rsp.scl_level    = high;
            rsp.sda_pull_low = (left_ff > 8'd1);
            if (q == 2'd3) begin
               left_dec = (left_ff != 8'd0) ? left_ff - 8'd1 : 8'd0;
               left_in  = left_dec;
               qtr_in   = 2'd0;
               if (left_dec != 8'd0) begin
                  phase_in = i2crm_pkg::PH_RX;
                  shift_in = 8'd0;
                  bit_in   = 4'd0;
               end else begin
                  phase_in  = i2crm_pkg::PH_STOP;
                  end_st_in = i2crm_pkg::STAT_OK;
               end
            end else begin
               qtr_in = q + 2'd1;
            end
         end

         // STOP, then report and arm the hold counter
         i2crm_pkg::PH_STOP: begin
            rsp.scl_level    = (q != 2'd0);
            rsp.sda_pull_low = ~q[1];
            if (q == 2'd3) begin
               rsp.done_res = 1'b1;
               rsp.status   = end_st_ff;
               if (end_st_ff == i2crm_pkg::STAT_DATA_NACK) begin
                  rsp.failed_byte = didx_wide[3:0];
               end
               if (!is_read_ff) begin
                  fill_in = '0;
               end
               hold_in  = cfg.stop_hold_ticks;
               phase_in = i2crm_pkg::PH_IDLE;
               qtr_in   = 2'd0;
            end else begin
               qtr_in = q + 2'd1;
            end
         end

         default: begin
            phase_in = i2crm_pkg::PH_IDLE;
            qtr_in   = 2'd0;
         end
      endcase

      rsp.busy_res = (phase_in != i2crm_pkg::PH_IDLE) || (hold_in != 16'd0);
   end

   // State registers advance only on an accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= i2crm_pkg::PH_IDLE;
         qtr_ff     <= 2'd0;
         bit_ff     <= 4'd0;
         shift_ff   <= 8'd0;
         left_ff    <= 8'd0;
         wait_ff    <= 8'd0;
         fill_ff    <= '0;
         hold_ff    <= 16'd0;
         treg_ff    <= 8'd0;
         is_read_ff <= 1'b0;
         end_st_ff  <= i2crm_pkg::STAT_OK;
         didx_ff    <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         qtr_ff     <= qtr_in;
         bit_ff     <= bit_in;
         shift_ff   <= shift_in;
         left_ff    <= left_in;
         wait_ff    <= wait_in;
         fill_ff    <= fill_in;
         hold_ff    <= hold_in;
         treg_ff    <= treg_in;
         is_read_ff <= is_read_in;
         end_st_ff  <= end_st_in;
         didx_ff    <= didx_in;
      end
   end

endmodule

// File: verif/i2c_register_master_tb.sv
// Self-checking testbench for the I2C register master: bus-tick predictor, slave responder, checks.
module i2c_register_master_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WRITE_DEPTH     = 16;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int STALL_LIMIT     = 2000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   i2crm_pkg::req_type req_data;
   logic               rsp_valid;
   logic               rsp_ready;
   i2crm_pkg::rsp_type rsp_data;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [15:0] csr_write_data;

   i2c_register_master #(.WRITE_DEPTH(WRITE_DEPTH)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Expected result beats, oldest first
   i2crm_pkg::rsp_type pending_tick_results[$];
   int      error_count      = 0;
   int      gap_pct          = 15;
   bit      rsp_hold_request = 1'b0;

   // Slave responder behavior for the current transfer
   int                   ack_delay  = 0;
   i2crm_pkg::phase_type nack_phase = i2crm_pkg::PH_IDLE;
   int                   nack_byte  = 0;

   // Predictor copy of the configuration and bus sequencer
   i2crm_pkg::cfg_type csr_shadow = '{device_address: i2crm_pkg::DEV_ADDR_RST,
                                      ack_timeout: i2crm_pkg::ACK_TMO_RST,
                                      stop_hold_ticks: i2crm_pkg::STOP_HOLD_RST};
   i2crm_pkg::phase_type bus_phase = i2crm_pkg::PH_IDLE;
   logic [1:0]  quarter        = '0;
   logic [3:0]  bit_count      = '0;
   logic [7:0]  shift_reg      = '0;
   logic [7:0]  bytes_to_read  = '0;
   logic [7:0]  ack_waits      = '0;
   logic [7:0]  wbuf [WRITE_DEPTH];
   logic [4:0]  wbuf_fill      = '0;
   logic [15:0] hold_left      = '0;
   logic [7:0]  reg_addr       = '0;
   logic        read_mode      = 1'b0;
   logic [2:0]  pending_status = i2crm_pkg::STAT_OK;
   logic [7:0]  data_idx       = '0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void load_byte(i2crm_pkg::phase_type ph, logic [7:0] value);
      bus_phase = ph;
      shift_reg = value;
      bit_count = '0;
      quarter   = '0;
   endfunction

   function automatic void enter_stop(logic [2:0] st);
      bus_phase      = i2crm_pkg::PH_STOP;
      quarter        = '0;
      pending_status = st;
   endfunction

   // Send the next buffered byte, or stop once the buffer is used up
   function automatic void next_write_beat();
      if (data_idx < wbuf_fill && data_idx < WRITE_DEPTH) begin
         load_byte(i2crm_pkg::PH_TX_DATA, wbuf[data_idx[3:0]]);
      end else begin
         enter_stop(i2crm_pkg::STAT_OK);
      end
   endfunction

   function automatic void start_receive();
      bus_phase = i2crm_pkg::PH_RX;
      shift_reg = '0;
      bit_count = '0;
      quarter   = '0;
   endfunction

   // Advance the predicted sequencer by one quarter-bit tick and return its line state
   function automatic i2crm_pkg::rsp_type bus_tick_result(i2crm_pkg::req_type b);
      i2crm_pkg::rsp_type r;
      logic [1:0]         q;
      logic               scl_high;
      r = '0;
      r.scl_level = 1'b1;
      q = quarter;
      scl_high = (q == 2'd1) || (q == 2'd2);

      // Commands are only taken when idle and past the stop hold
      if (bus_phase == i2crm_pkg::PH_IDLE) begin
         if (hold_left != 0) begin
            hold_left--;
         end else if (b.func == i2crm_pkg::FUNC_PUSH) begin
            if (wbuf_fill < WRITE_DEPTH) begin
               wbuf[wbuf_fill[3:0]] = b.write_byte;
               wbuf_fill++;
            end
         end else if (b.func == i2crm_pkg::FUNC_WRITE || b.func == i2crm_pkg::FUNC_READ) begin
            reg_addr       = b.register_address;
            read_mode      = (b.func == i2crm_pkg::FUNC_READ);
            bytes_to_read  = read_mode ? b.read_count : 8'd0;
            data_idx       = '0;
            pending_status = i2crm_pkg::STAT_OK;
            bus_phase      = i2crm_pkg::PH_START1;
            quarter        = '0;
            q              = '0;
            scl_high       = 1'b0;
         end
      end

      case (bus_phase)
         i2crm_pkg::PH_IDLE: begin
         end
         i2crm_pkg::PH_START1, i2crm_pkg::PH_START2: begin
            r.scl_level    = scl_high;
            r.sda_pull_low = (q >= 2'd2);
            if (q == 2'd3) begin
               if (bus_phase == i2crm_pkg::PH_START1) begin
                  load_byte(i2crm_pkg::PH_TX_ADDR_W, {csr_shadow.device_address, 1'b0});
               end else begin
                  load_byte(i2crm_pkg::PH_TX_ADDR_R, {csr_shadow.device_address, 1'b1});
               end
            end else begin
               quarter = q + 2'd1;
            end
         end
         i2crm_pkg::PH_TX_ADDR_W, i2crm_pkg::PH_TX_REG,
         i2crm_pkg::PH_TX_DATA, i2crm_pkg::PH_TX_ADDR_R: begin
            r.scl_level    = scl_high;
            r.sda_pull_low = ~shift_reg[7];
            if (q == 2'd3) begin
               shift_reg = shift_reg << 1;
               bit_count++;
               if (bit_count >= 4'd8) begin
                  case (bus_phase)
                     i2crm_pkg::PH_TX_ADDR_W: bus_phase = i2crm_pkg::PH_ACK_ADDR_W;
                     i2crm_pkg::PH_TX_REG:    bus_phase = i2crm_pkg::PH_ACK_REG;
                     i2crm_pkg::PH_TX_DATA:   bus_phase = i2crm_pkg::PH_ACK_DATA;
                     default:                 bus_phase = i2crm_pkg::PH_ACK_ADDR_R;
                  endcase
                  bit_count = '0;
                  ack_waits = '0;
               end
               quarter = '0;
            end else begin
               quarter = q + 2'd1;
            end
         end
         i2crm_pkg::PH_ACK_ADDR_W, i2crm_pkg::PH_ACK_REG,
         i2crm_pkg::PH_ACK_DATA, i2crm_pkg::PH_ACK_ADDR_R: begin
            r.scl_level = scl_high;
            // SCL stays high at the sample quarter until the slave pulls SDA low
            if (q == 2'd2) begin
               if (!b.sda_sample) begin
                  quarter = 2'd3;
               end else begin
                  if (ack_waits < i2crm_pkg::ACK_WAIT_MAX) ack_waits++;
                  if (ack_waits >= csr_shadow.ack_timeout) begin
                     case (bus_phase)
                        i2crm_pkg::PH_ACK_ADDR_W: enter_stop(i2crm_pkg::STAT_ADDR_NACK);
                        i2crm_pkg::PH_ACK_REG:    enter_stop(i2crm_pkg::STAT_REG_NACK);
                        i2crm_pkg::PH_ACK_ADDR_R: enter_stop(i2crm_pkg::STAT_RADDR_NACK);
                        default:                  enter_stop(i2crm_pkg::STAT_DATA_NACK);
                     endcase
                  end
               end
            end else if (q == 2'd3) begin
               case (bus_phase)
                  i2crm_pkg::PH_ACK_ADDR_W: load_byte(i2crm_pkg::PH_TX_REG, reg_addr);
                  i2crm_pkg::PH_ACK_REG: begin
                     if (read_mode) begin
                        bus_phase = i2crm_pkg::PH_START2;
                        quarter   = '0;
                     end else begin
                        next_write_beat();
                     end
                  end
                  i2crm_pkg::PH_ACK_DATA: begin
                     data_idx++;
                     next_write_beat();
                  end
                  default: begin
                     if (bytes_to_read != 0) start_receive();
                     else enter_stop(i2crm_pkg::STAT_OK);
                  end
               endcase
            end else begin
               quarter = q + 2'd1;
            end
         end
         i2crm_pkg::PH_RX: begin
            r.scl_level = scl_high;
            if (q == 2'd2) begin
               shift_reg = {shift_reg[6:0], b.sda_sample};
               if (bit_count == 4'd7) begin
                  r.read_valid = 1'b1;
                  r.read_data  = shift_reg;
                  r.read_last  = (bytes_to_read == 8'd1);
               end
               quarter = 2'd3;
            end else if (q == 2'd3) begin
               bit_count++;
               if (bit_count >= 4'd8) begin
                  bit_count = '0;
                  bus_phase = i2crm_pkg::PH_MACK;
               end
               quarter = '0;
            end else begin
               quarter = q + 2'd1;
            end
         end
         i2crm_pkg::PH_MACK: begin
            // Master ACKs every byte but the last
            r.scl_level    = scl_high;
            r.sda_pull_low = (bytes_to_read > 8'd1);
            if (q == 2'd3) begin
               if (bytes_to_read != 0) bytes_to_read--;
               if (bytes_to_read != 0) start_receive();
               else enter_stop(i2crm_pkg::STAT_OK);
            end else begin
               quarter = q + 2'd1;
            end
         end
         i2crm_pkg::PH_STOP: begin
            r.scl_level    = (q != 2'd0);
            r.sda_pull_low = (q < 2'd2);
            if (q == 2'd3) begin
               r.done_res    = 1'b1;
               r.status      = pending_status;
               r.failed_byte = (pending_status == i2crm_pkg::STAT_DATA_NACK) ? data_idx[3:0]
                                                                             : 4'd0;
               if (!read_mode) wbuf_fill = '0;
               hold_left = csr_shadow.stop_hold_ticks;
               bus_phase = i2crm_pkg::PH_IDLE;
               quarter   = '0;
            end else begin
               quarter = q + 2'd1;
            end
         end
         default: begin
            bus_phase = i2crm_pkg::PH_IDLE;
            quarter   = '0;
         end
      endcase

      r.busy_res = (bus_phase != i2crm_pkg::PH_IDLE) || (hold_left != 0);
      return r;
   endfunction

   // SDA level the slave presents on this tick
   function automatic logic slave_sda();
      logic ack_slot;
      ack_slot = (bus_phase == i2crm_pkg::PH_ACK_ADDR_W) ||
                 (bus_phase == i2crm_pkg::PH_ACK_REG) ||
                 (bus_phase == i2crm_pkg::PH_ACK_DATA) ||
                 (bus_phase == i2crm_pkg::PH_ACK_ADDR_R);
      if (!ack_slot || quarter != 2'd2) return 1'($urandom_range(0, 1));
      if (bus_phase == nack_phase &&
          (bus_phase != i2crm_pkg::PH_ACK_DATA || data_idx == nack_byte))
         return 1'b1;
      return (ack_waits < ack_delay);
   endfunction

   // Send one tick beat, with an optional gap before it, and record its expected result
   task automatic send_tick(logic [1:0] fn, logic [7:0] reg_a, logic [7:0] wbyte,
                            logic [7:0] count);
      i2crm_pkg::req_type beat;
      beat.func             = fn;
      beat.sda_sample       = slave_sda();
      beat.register_address = reg_a;
      beat.write_byte       = wbyte;
      beat.read_count       = count;
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 4)) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_ready !== 1'b1);
      pending_tick_results.push_back(bus_tick_result(beat));
   endtask

   // Keep ticking with random commands, all ignored, until the bus and stop hold are done
   task automatic finish_transfer();
      while (bus_phase != i2crm_pkg::PH_IDLE || hold_left != 0)
         send_tick(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic register_write(logic [7:0] reg_a, int n_bytes);
      repeat (n_bytes)
         send_tick(i2crm_pkg::FUNC_PUSH, 8'($urandom), 8'($urandom), 8'($urandom));
      send_tick(i2crm_pkg::FUNC_WRITE, reg_a, 8'($urandom), 8'($urandom));
      finish_transfer();
   endtask

   task automatic register_read(logic [7:0] reg_a, logic [7:0] count);
      send_tick(i2crm_pkg::FUNC_READ, reg_a, 8'($urandom), count);
      finish_transfer();
   endtask

   // Stop offering beats and wait until every expected result beat is back
   task automatic quiesce();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_tick_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic configure(logic [6:0] addr, logic [7:0] tmo, logic [15:0] hold);
      quiesce();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= i2crm_pkg::CSR_DEV_ADDR;
      csr_write_data   <= {9'd0, addr};
      @(negedge clock);
      csr_index        <= i2crm_pkg::CSR_ACK_TMO;
      csr_write_data   <= {8'd0, tmo};
      @(negedge clock);
      csr_index        <= i2crm_pkg::CSR_STOP_HOLD;
      csr_write_data   <= hold;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      csr_shadow = '{device_address: addr, ack_timeout: tmo, stop_hold_ticks: hold};
   endtask

   // Reset register values; the receiver holds off long enough to stall the input
   task automatic test_backpressure();
      gap_pct = 0;
      ack_delay = 0;
      rsp_hold_request = 1'b1;
      register_read(8'hFF, 8'd2);
      gap_pct = 15;
   endtask

   task automatic test_write_buffer();
      configure(7'h11, 8'd4, 16'd0);
      ack_delay = 1;
      // Zero count read: STOP right after the read address, buffer kept
      send_tick(i2crm_pkg::FUNC_PUSH, 8'($urandom), 8'($urandom), 8'($urandom));
      register_read(8'h20, 8'd0);
      // The byte pushed before the read goes out now
      register_write(8'h21, 0);
      ack_delay = 0;
   endtask

   // A missing ACK in each phase; timeout 0 behaves like 1
   task automatic test_ack_timeouts();
      configure(7'h55, 8'd0, 16'd0);
      nack_phase = i2crm_pkg::PH_ACK_ADDR_W;
      register_write(8'h12, 0);
      configure(7'h2A, 8'd1, 16'd0);
      nack_phase = i2crm_pkg::PH_ACK_REG;
      register_write(8'h34, 0);
      configure(7'h33, 8'd2, 16'd0);
      nack_phase = i2crm_pkg::PH_ACK_ADDR_R;
      register_read(8'h56, 8'd3);
      configure(7'h4C, 8'd3, 16'd0);
      nack_phase = i2crm_pkg::PH_ACK_DATA;
      nack_byte  = 1;
      register_write(8'hA5, 2);
      nack_phase = i2crm_pkg::PH_IDLE;
      ack_delay  = 0;
   endtask

   // Empty write; commands during the stop hold are ignored
   task automatic test_stop_hold();
      configure(7'h68, 8'd8, 16'd3);
      register_write(8'h01, 0);
   endtask

   // Result side: random stall bursts, or one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_request) begin
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
            rsp_hold_request = 1'b0;
         end else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endtask

   // Compare each result beat with the oldest expectation
   initial begin : result_checker
      i2crm_pkg::rsp_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            if (pending_tick_results.size() == 0) begin
               $error("result beat with no expectation waiting");
               error_count++;
            end else begin
               want = pending_tick_results.pop_front();
               check_field("scl_level", want.scl_level, rsp_data.scl_level);
               check_field("sda_pull_low", want.sda_pull_low, rsp_data.sda_pull_low);
               check_field("busy_res", want.busy_res, rsp_data.busy_res);
               check_field("read_data", want.read_data, rsp_data.read_data);
               check_field("read_valid", want.read_valid, rsp_data.read_valid);
               check_field("read_last", want.read_last, rsp_data.read_last);
               check_field("done_res", want.done_res, rsp_data.done_res);
               check_field("status", want.status, rsp_data.status);
               check_field("failed_byte", want.failed_byte, rsp_data.failed_byte);
            end
         end
      end
   end

   // Watchdog: too many cycles with no beat moving on either side
   initial begin : stall_watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_ready === 1'b1) ||
             (rsp_valid === 1'b1 && rsp_ready === 1'b1)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_write_enable = 1'b0;
      csr_index        = i2crm_pkg::CSR_DEV_ADDR;
      csr_write_data   = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_backpressure();
      test_write_buffer();
      test_ack_timeouts();
      gap_pct = 0;
      test_stop_hold();
      quiesce();

      if (error_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
